// ===== hdl/pssm_pkg.sv =====
// Package: constants, types and helpers of the parity serial sensor master
`default_nettype none
package pssm_pkg;

    localparam int FRAME_W = 11;
    localparam int VALUE_W = 10;
    localparam int TICK_W  = 16;
    localparam int COUNT_W = 4;

    localparam logic [COUNT_W-1:0] FRAME_BITS   = 4'd11;
    localparam logic [FRAME_W-1:0] CAP_VALUE    = 11'h400;
    localparam logic [VALUE_W-1:0] VALUE_LIMIT  = 10'd1020;
    localparam logic [TICK_W-1:0]  HALF_PERIOD_RESET = 16'd200;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam logic [QUEUE_AW:0] QUEUE_FULL = (QUEUE_AW+1)'(QUEUE_DEPTH);

    typedef enum logic [4:0] {
        PH_IDLE          = 5'd0,
        PH_START_HI      = 5'd1,
        PH_START_DATA_LO = 5'd2,
        PH_START_CLK_LO  = 5'd3,
        PH_DIR_HI        = 5'd4,
        PH_DIR_LO        = 5'd5,
        PH_RELEASE       = 5'd6,
        PH_RD_HI         = 5'd7,
        PH_RD_LO         = 5'd8,
        PH_WR_HI         = 5'd9,
        PH_WR_LO         = 5'd10,
        PH_STOP_GAP      = 5'd11,
        PH_STOP_DATA_LO  = 5'd12,
        PH_STOP_CLK_HI   = 5'd13,
        PH_STOP_DATA_HI  = 5'd14
    } phase_t;

    typedef struct packed {
        logic               req_valid;
        logic               req_type;
        logic [FRAME_W-1:0] frame;
        logic               sda_in;
    } tick_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    typedef struct packed {
        logic               scl_out;
        logic               sda_out;
        logic               sda_drive;
        logic               ready_res;
        logic               done_res;
        logic [FRAME_W-1:0] read_value;
        logic               parity_ok;
        logic               value_in_range;
    } result_t;

    function automatic logic [FRAME_W-1:0] make_frame(input logic [VALUE_W-1:0] value);
        make_frame = {^value, value};
    endfunction

endpackage
`default_nettype wire

// ===== hdl/pssm_if.sv =====
// Interfaces: request, result and configuration channels
`default_nettype none
interface pssm_req_if import pssm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               req_valid;
    logic               req_type;
    logic [VALUE_W-1:0] write_value;
    logic               sda_in;

    modport source (output valid, req_valid, req_type, write_value, sda_in, input ready);
    modport sink (input valid, req_valid, req_type, write_value, sda_in, output ready);
endinterface

interface pssm_res_if import pssm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               scl_out;
    logic               sda_out;
    logic               sda_drive;
    logic               ready_res;
    logic               done_res;
    logic [FRAME_W-1:0] read_value;
    logic               parity_ok;
    logic               value_in_range;

    modport source (output valid, scl_out, sda_out, sda_drive, ready_res, done_res,
                    read_value, parity_ok, value_in_range, input ready);
    modport sink (input valid, scl_out, sda_out, sda_drive, ready_res, done_res,
                  read_value, parity_ok, value_in_range, output ready);
endinterface

interface pssm_cfg_if import pssm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TICK_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/pssm_front.sv =====
// Front end: accept requests and build the outgoing frame with its parity bit
`default_nettype none
module pssm_front import pssm_pkg::*; (
    pssm_req_if.sink   req,
    input  queue_stat_t stat,
    output logic        push,
    output tick_item_t  item
);

    assign req.ready = !stat.full;
    assign push      = req.valid && !stat.full;

    always_comb
    begin
        item.req_valid = req.req_valid;
        item.req_type  = req.req_type;
        item.frame     = req.req_type ? make_frame(req.write_value) : '0;
        item.sda_in    = req.sda_in;
    end

endmodule
`default_nettype wire

// ===== hdl/pssm_queue.sv =====
// Short queue between front end and sequencer
`default_nettype none
module pssm_queue import pssm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  tick_item_t  push_item,
    input  logic        pop,
    output tick_item_t  pop_item,
    output queue_stat_t stat
);

    tick_item_t          slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    assign pop_item   = slot_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == QUEUE_FULL);
    assign stat.empty = (count_reg == '0);

endmodule
`default_nettype wire

// ===== hdl/pssm_back.sv =====
// Back end: line sequencer, read result check and output register
`default_nettype none
module pssm_back import pssm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  queue_stat_t stat,
    input  tick_item_t  item,
    output logic        pop,
    pssm_cfg_if.sink    cfg,
    pssm_res_if.source  res
);

    logic [TICK_W-1:0]  half_period_reg;
    phase_t             phase_reg,       phase_next;
    logic [COUNT_W-1:0] bit_count_reg,   bit_count_next;
    logic [TICK_W-1:0]  wait_count_reg,  wait_count_next;
    logic [FRAME_W-1:0] frame_shift_reg, frame_shift_next;
    logic               is_write_reg,    is_write_next;
    logic               clock_level_reg, clock_level_next;
    logic               data_level_reg,  data_level_next;
    logic               drive_level_reg, drive_level_next;
    logic [FRAME_W-1:0] last_result_reg, last_result_next;
    logic               last_parity_reg, last_parity_next;
    logic               res_valid_reg;
    result_t            res_data_reg;
    result_t            res_data_next;
    logic               ready_flag;
    logic               done_flag;
    logic               load;
    logic               parity_good;
    logic [FRAME_W-1:0] rd_capped;
    logic [FRAME_W-1:0] rd_result;

    assign pop       = !stat.empty && (!res_valid_reg || res.ready);
    assign cfg.ready = 1'b1;

    always_comb
    begin
        parity_good = (frame_shift_reg[FRAME_W-1] == ^frame_shift_reg[VALUE_W-1:0]);
        rd_capped   = (frame_shift_reg > CAP_VALUE) ? CAP_VALUE : frame_shift_reg;
        rd_result   = (parity_good && frame_shift_reg[VALUE_W-1:0] < VALUE_LIMIT)
                    ? {1'b0, frame_shift_reg[VALUE_W-1:0]} : rd_capped;
    end

    always_comb
    begin
        phase_next       = phase_reg;
        bit_count_next   = bit_count_reg;
        wait_count_next  = wait_count_reg;
        frame_shift_next = frame_shift_reg;
        is_write_next    = is_write_reg;
        clock_level_next = clock_level_reg;
        data_level_next  = data_level_reg;
        drive_level_next = drive_level_reg;
        last_result_next = last_result_reg;
        last_parity_next = last_parity_reg;
        ready_flag       = 1'b0;
        done_flag        = 1'b0;
        load             = 1'b0;
        if (pop)
        begin
            load = 1'b1;
            if (phase_reg == PH_IDLE)
            begin
                ready_flag = 1'b1;
                load       = 1'b0;
                if (item.req_valid)
                begin
                    is_write_next    = item.req_type;
                    frame_shift_next = item.frame;
                    bit_count_next   = '0;
                    clock_level_next = 1'b1;
                    data_level_next  = 1'b1;
                    drive_level_next = 1'b1;
                    phase_next       = PH_START_HI;
                    load             = 1'b1;
                end
            end
            else if (wait_count_reg != '0)
            begin
                wait_count_next = wait_count_reg - 1'b1;
                load            = 1'b0;
            end
            else
            begin
                case (phase_reg)
                    PH_START_HI:
                    begin
                        data_level_next = 1'b0;
                        phase_next      = PH_START_DATA_LO;
                    end
                    PH_START_DATA_LO:
                    begin
                        clock_level_next = 1'b0;
                        phase_next       = PH_START_CLK_LO;
                    end
                    PH_START_CLK_LO:
                    begin
                        data_level_next  = !is_write_reg;
                        clock_level_next = 1'b1;
                        phase_next       = PH_DIR_HI;
                    end
                    PH_DIR_HI:
                    begin
                        clock_level_next = 1'b0;
                        phase_next       = PH_DIR_LO;
                    end
                    PH_DIR_LO, PH_WR_LO:
                    begin
                        if (is_write_reg && bit_count_reg < FRAME_BITS)
                        begin
                            data_level_next  = frame_shift_reg[FRAME_W-1];
                            frame_shift_next = {frame_shift_reg[FRAME_W-2:0], 1'b0};
                            bit_count_next   = bit_count_reg + 1'b1;
                            clock_level_next = 1'b1;
                            phase_next       = PH_WR_HI;
                        end
                        else if (is_write_reg)
                        begin
                            phase_next = PH_STOP_GAP;
                        end
                        else
                        begin
                            data_level_next  = 1'b1;
                            drive_level_next = 1'b0;
                            phase_next       = PH_RELEASE;
                        end
                    end
                    PH_RELEASE, PH_RD_LO:
                    begin
                        if (bit_count_reg < FRAME_BITS)
                        begin
                            clock_level_next = 1'b1;
                            frame_shift_next = {frame_shift_reg[FRAME_W-2:0], item.sda_in};
                            bit_count_next   = bit_count_reg + 1'b1;
                            phase_next       = PH_RD_HI;
                        end
                        else
                        begin
                            data_level_next  = 1'b0;
                            drive_level_next = 1'b1;
                            phase_next       = PH_STOP_DATA_LO;
                        end
                    end
                    PH_RD_HI:
                    begin
                        clock_level_next = 1'b0;
                        phase_next       = PH_RD_LO;
                    end
                    PH_WR_HI:
                    begin
                        clock_level_next = 1'b0;
                        phase_next       = PH_WR_LO;
                    end
                    PH_STOP_GAP:
                    begin
                        data_level_next  = 1'b0;
                        drive_level_next = 1'b1;
                        phase_next       = PH_STOP_DATA_LO;
                    end
                    PH_STOP_DATA_LO:
                    begin
                        clock_level_next = 1'b1;
                        phase_next       = PH_STOP_CLK_HI;
                    end
                    PH_STOP_CLK_HI:
                    begin
                        data_level_next = 1'b1;
                        phase_next      = PH_STOP_DATA_HI;
                    end
                    PH_STOP_DATA_HI:
                    begin
                        if (!is_write_reg)
                        begin
                            last_result_next = rd_result;
                            last_parity_next = parity_good;
                        end
                        done_flag        = 1'b1;
                        clock_level_next = 1'b1;
                        data_level_next  = 1'b1;
                        drive_level_next = 1'b1;
                        phase_next       = PH_IDLE;
                        load             = 1'b0;
                    end
                    default:
                    begin
                        clock_level_next = 1'b1;
                        data_level_next  = 1'b1;
                        drive_level_next = 1'b1;
                        phase_next       = PH_IDLE;
                        load             = 1'b0;
                    end
                endcase
            end
            if (load)
                wait_count_next = half_period_reg;
        end

        res_data_next.scl_out        = clock_level_next;
        res_data_next.sda_out        = data_level_next;
        res_data_next.sda_drive      = drive_level_next;
        res_data_next.ready_res      = ready_flag;
        res_data_next.done_res       = done_flag;
        res_data_next.read_value     = last_result_next;
        res_data_next.parity_ok      = last_parity_next;
        res_data_next.value_in_range = (last_result_next < CAP_VALUE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
            phase_reg       <= PH_IDLE;
            bit_count_reg   <= '0;
            wait_count_reg  <= '0;
            frame_shift_reg <= '0;
            is_write_reg    <= 1'b0;
            clock_level_reg <= 1'b1;
            data_level_reg  <= 1'b1;
            drive_level_reg <= 1'b1;
            last_result_reg <= '0;
            last_parity_reg <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
                half_period_reg <= cfg.data;
            phase_reg       <= phase_next;
            bit_count_reg   <= bit_count_next;
            wait_count_reg  <= wait_count_next;
            frame_shift_reg <= frame_shift_next;
            is_write_reg    <= is_write_next;
            clock_level_reg <= clock_level_next;
            data_level_reg  <= data_level_next;
            drive_level_reg <= drive_level_next;
            last_result_reg <= last_result_next;
            last_parity_reg <= last_parity_next;
            if (pop)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            res_data_reg <= res_data_next;
    end

    assign res.valid          = res_valid_reg;
    assign res.scl_out        = res_data_reg.scl_out;
    assign res.sda_out        = res_data_reg.sda_out;
    assign res.sda_drive      = res_data_reg.sda_drive;
    assign res.ready_res      = res_data_reg.ready_res;
    assign res.done_res       = res_data_reg.done_res;
    assign res.read_value     = res_data_reg.read_value;
    assign res.parity_ok      = res_data_reg.parity_ok;
    assign res.value_in_range = res_data_reg.value_in_range;

endmodule
`default_nettype wire

// ===== hdl/parity_serial_sensor_master_top.sv =====
// Top level of the parity serial sensor master
//
// Channels: req carries one line tick per request (an optional read or write
// request plus the sampled data line); res returns one result per tick with
// the clock and data line levels, drive enable, ready and done flags and the
// last checked read value; cfg writes the 16-bit half period in ticks.
// A request is written into the queue, then into the result register; ticks
// flow at one per cycle while the receiver takes results, as the back-end line
// sequencer pops one queued tick per cycle while the result register is free or taken.
// A two-entry queue sits between the front end and the sequencer; the result
// register holds while the receiver stalls, the queue then fills and req.ready
// drops until the receiver takes the pending result.
// Reset: sequencer idle, lines high and driven, queue empty, no result
// pending, half period 200 ticks, last read value zero.
// Configuration is taken in any cycle and applies from the next hold.
`default_nettype none
module parity_serial_sensor_master_top import pssm_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    pssm_req_if.sink    req,
    pssm_res_if.source  res,
    pssm_cfg_if.sink    cfg
);

    queue_stat_t stat;
    logic        push;
    logic        pop;
    tick_item_t  push_item;
    tick_item_t  pop_item;

    pssm_front u_front (
        .req  (req),
        .stat (stat),
        .push (push),
        .item (push_item)
    );

    pssm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .stat      (stat)
    );

    pssm_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .item  (pop_item),
        .pop   (pop),
        .cfg   (cfg),
        .res   (res)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !(res.ready_res && res.done_res))
        else $error("ready and done flagged on the same tick");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.done_res) |-> (res.scl_out && res.sda_out && res.sda_drive))
        else $error("lines not returned high at end of transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.sda_drive) |-> res.sda_out)
        else $error("data level low while line is released");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(stat.full && stat.empty))
        else $error("queue reports full and empty at once");

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Testbench for the parity serial sensor master: line-level prediction, directed and random frames
`timescale 1ns / 1ps

module tb_top;
    import pssm_pkg::*;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;
    localparam int   CYCLE_LIMIT   = 600000;
    localparam int   RANDOM_TICKS  = 40;
    localparam int   REPORT_LIMIT  = 10;
    localparam int   SETTLE_CYCLES = 20;

    logic clk = 1'b0;
    logic rst_n;

    pssm_req_if req_ch();
    pssm_res_if res_ch();
    pssm_cfg_if cfg_ch();

    parity_serial_sensor_master_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // line sequencer prediction state
    phase_t             line_phase  = PH_IDLE;
    logic [COUNT_W-1:0] bit_idx     = '0;
    logic [TICK_W-1:0]  hold_left   = '0;
    logic [FRAME_W-1:0] frame_bits  = '0;
    logic               write_mode  = 1'b0;
    logic               scl_lvl     = 1'b1;
    logic               sda_lvl     = 1'b1;
    logic               drv_lvl     = 1'b1;
    logic [FRAME_W-1:0] read_result = '0;
    logic               read_parity = 1'b0;
    logic [TICK_W-1:0]  half_period = HALF_PERIOD_RESET;

    result_t pending_line_states[$];

    int  cycle_count    = 0;
    int  mismatch_count = 0;
    int  lines_checked  = 0;
    int  ticks_sent     = 0;
    int  reads_started  = 0;
    int  writes_started = 0;
    int  stall_left     = 0;
    bit  src_idle_en    = 1'b1;
    bit  snk_idle_en    = 1'b1;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    function automatic int draw_gap(input bit enabled);
        if (!enabled)
            return 0;
        if ($urandom_range(0, 2) == 0)
            return $urandom_range(0, 17);
        return $urandom_range(0, 1);
    endfunction

    function automatic result_t advance_line_model(input logic rv, input logic rt,
                                                   input logic [VALUE_W-1:0] wv,
                                                   input logic sda);
        result_t line;
        logic    reload;
        logic    took;
        logic    fin;
        logic    parity_good;
        took   = 1'b0;
        fin    = 1'b0;
        reload = 1'b1;
        if (line_phase == PH_IDLE)
        begin
            took   = 1'b1;
            reload = 1'b0;
            if (rv)
            begin
                write_mode = rt;
                frame_bits = rt ? {^wv, wv} : '0;
                bit_idx    = '0;
                scl_lvl    = 1'b1;
                sda_lvl    = 1'b1;
                drv_lvl    = 1'b1;
                line_phase = PH_START_HI;
                reload     = 1'b1;
            end
        end
        else if (hold_left != '0)
        begin
            hold_left = hold_left - 1'b1;
            reload    = 1'b0;
        end
        else
        begin
            case (line_phase)
                PH_START_HI:
                begin
                    sda_lvl    = 1'b0;
                    line_phase = PH_START_DATA_LO;
                end
                PH_START_DATA_LO:
                begin
                    scl_lvl    = 1'b0;
                    line_phase = PH_START_CLK_LO;
                end
                PH_START_CLK_LO:
                begin
                    sda_lvl    = ~write_mode;
                    scl_lvl    = 1'b1;
                    line_phase = PH_DIR_HI;
                end
                PH_DIR_HI:
                begin
                    scl_lvl    = 1'b0;
                    line_phase = PH_DIR_LO;
                end
                PH_DIR_LO, PH_WR_LO:
                begin
                    if (write_mode && bit_idx < FRAME_BITS)
                    begin
                        sda_lvl    = frame_bits[FRAME_W-1];
                        frame_bits = frame_bits << 1;
                        bit_idx    = bit_idx + 1'b1;
                        scl_lvl    = 1'b1;
                        line_phase = PH_WR_HI;
                    end
                    else if (write_mode)
                    begin
                        line_phase = PH_STOP_GAP;
                    end
                    else
                    begin
                        sda_lvl    = 1'b1;
                        drv_lvl    = 1'b0;
                        line_phase = PH_RELEASE;
                    end
                end
                PH_RELEASE, PH_RD_LO:
                begin
                    if (bit_idx < FRAME_BITS)
                    begin
                        scl_lvl    = 1'b1;
                        frame_bits = {frame_bits[FRAME_W-2:0], sda};
                        bit_idx    = bit_idx + 1'b1;
                        line_phase = PH_RD_HI;
                    end
                    else
                    begin
                        sda_lvl    = 1'b0;
                        drv_lvl    = 1'b1;
                        line_phase = PH_STOP_DATA_LO;
                    end
                end
                PH_RD_HI:
                begin
                    scl_lvl    = 1'b0;
                    line_phase = PH_RD_LO;
                end
                PH_WR_HI:
                begin
                    scl_lvl    = 1'b0;
                    line_phase = PH_WR_LO;
                end
                PH_STOP_GAP:
                begin
                    sda_lvl    = 1'b0;
                    drv_lvl    = 1'b1;
                    line_phase = PH_STOP_DATA_LO;
                end
                PH_STOP_DATA_LO:
                begin
                    scl_lvl    = 1'b1;
                    line_phase = PH_STOP_CLK_HI;
                end
                PH_STOP_CLK_HI:
                begin
                    sda_lvl    = 1'b1;
                    line_phase = PH_STOP_DATA_HI;
                end
                default:
                begin
                    if (line_phase == PH_STOP_DATA_HI && !write_mode)
                    begin
                        parity_good = frame_bits[FRAME_W-1] == ^frame_bits[VALUE_W-1:0];
                        if (parity_good && frame_bits[VALUE_W-1:0] < VALUE_LIMIT)
                            read_result = {1'b0, frame_bits[VALUE_W-1:0]};
                        else
                            read_result = (frame_bits > CAP_VALUE) ? CAP_VALUE : frame_bits;
                        read_parity = parity_good;
                    end
                    fin        = (line_phase == PH_STOP_DATA_HI);
                    scl_lvl    = 1'b1;
                    sda_lvl    = 1'b1;
                    drv_lvl    = 1'b1;
                    line_phase = PH_IDLE;
                    reload     = 1'b0;
                end
            endcase
        end
        if (reload)
            hold_left = half_period;

        line.scl_out        = scl_lvl;
        line.sda_out        = sda_lvl;
        line.sda_drive      = drv_lvl;
        line.ready_res      = took;
        line.done_res       = fin;
        line.read_value     = read_result;
        line.parity_ok      = read_parity;
        line.value_in_range = read_result < CAP_VALUE;
        return line;
    endfunction

    // drive the planned frame bit on ticks where the sequencer samples the line
    function automatic logic pick_sda(input logic [FRAME_W-1:0] frame);
        if (!write_mode && (line_phase == PH_RELEASE || line_phase == PH_RD_LO)
            && hold_left == '0 && bit_idx < FRAME_BITS)
            return frame[FRAME_W - 1 - int'(bit_idx)];
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [FRAME_W-1:0] draw_sensor_frame();
        logic [VALUE_W-1:0] v;
        v = 10'($urandom_range(0, 1023));
        case ($urandom_range(0, 5))
            0: return 11'($urandom_range(0, 2047));
            1:
            begin
                v = 10'($urandom_range(0, 1019));
                return {^v, v};
            end
            2:
            begin
                v = 10'($urandom_range(1020, 1023));
                return {^v, v};
            end
            3: return {~^v, v};
            4: return CAP_VALUE + 11'($urandom_range(0, 7));
            default: return {^v, v};
        endcase
    endfunction

    task automatic send_tick(input logic rv, input logic rt,
                             input logic [VALUE_W-1:0] wv, input logic sda);
        int      gap;
        result_t line;
        gap = draw_gap(src_idle_en);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_valid   <= rv;
        req_ch.req_type    <= rt;
        req_ch.write_value <= wv;
        req_ch.sda_in      <= sda;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        line = advance_line_model(rv, rt, wv, sda);
        pending_line_states.push_back(line);
        ticks_sent++;
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_line_states.size() != 0);
    endtask

    task automatic load_half_period(input logic [TICK_W-1:0] ticks);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= ticks;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        cfg_ch.valid <= 1'b0;
        half_period = ticks;
    endtask

    task automatic start_request(input logic rt, input logic [VALUE_W-1:0] wv);
        if (rt == REQ_WRITE)
            writes_started++;
        else
            reads_started++;
        send_tick(1'b1, rt, wv, 1'($urandom_range(0, 1)));
    endtask

    // run the line until the stop completes; requests offered meanwhile are noise
    task automatic finish_transaction(input logic [FRAME_W-1:0] frame);
        while (line_phase != PH_IDLE)
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      10'($urandom_range(0, 1023)), pick_sda(frame));
    endtask

    task automatic run_transaction(input logic rt, input logic [VALUE_W-1:0] wv,
                                   input logic [FRAME_W-1:0] frame);
        start_request(rt, wv);
        finish_transaction(frame);
    endtask

    task automatic test_idle_after_reset();
        repeat (4)
            send_tick(1'b0, 1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                      1'($urandom_range(0, 1)));
    endtask

    task automatic test_directed_writes();
        load_half_period('0);
        run_transaction(REQ_WRITE, 10'h3FF, '0);
        run_transaction(REQ_WRITE, 10'h2AA, '0);
    endtask

    task automatic test_directed_reads();
        run_transaction(REQ_READ, '0, 11'h7FB);
        run_transaction(REQ_READ, '0, 11'h3FC);
        run_transaction(REQ_READ, '0, 11'h7FF);
        run_transaction(REQ_READ, '0, 11'h400);
        run_transaction(REQ_READ, '0, 11'h401);
        run_transaction(REQ_READ, '0, 11'h001);
    endtask

    task automatic test_hold_lengths();
        load_half_period(16'd1);
        run_transaction(REQ_READ, '0, draw_sensor_frame());
        load_half_period(16'd2);
        run_transaction(REQ_WRITE, 10'($urandom_range(0, 1023)), '0);
    endtask

    // a long hold, then a shorter period written while the line is mid-request
    task automatic test_long_hold_change();
        logic [FRAME_W-1:0] frame;
        frame       = draw_sensor_frame();
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
        load_half_period(16'd8);
        start_request(REQ_READ, 10'($urandom_range(0, 1023)));
        repeat (3)
            send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
        load_half_period(16'd1);
        finish_transaction(frame);
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
    endtask

    task automatic test_random_traffic();
        int first_tick;
        first_tick = ticks_sent;
        while (ticks_sent - first_tick < RANDOM_TICKS)
        begin
            src_idle_en = ($urandom_range(0, 3) != 0);
            snk_idle_en = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0)
                load_half_period(TICK_W'(($urandom_range(0, 4) == 0) ? $urandom_range(4, 12)
                                                                     : $urandom_range(0, 3)));
            repeat ($urandom_range(0, 2))
                send_tick(1'b0, 1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                          1'($urandom_range(0, 1)));
            run_transaction(1'($urandom_range(0, 1)), 10'($urandom_range(0, 1023)),
                            draw_sensor_frame());
        end
        src_idle_en = 1'b1;
        snk_idle_en = 1'b1;
    endtask

    always @(posedge clk)
    begin : result_monitor
        result_t got;
        result_t want;
        string   bad;
        if (res_ch.valid && res_ch.ready)
        begin
            got.scl_out        = res_ch.scl_out;
            got.sda_out        = res_ch.sda_out;
            got.sda_drive      = res_ch.sda_drive;
            got.ready_res      = res_ch.ready_res;
            got.done_res       = res_ch.done_res;
            got.read_value     = res_ch.read_value;
            got.parity_ok      = res_ch.parity_ok;
            got.value_in_range = res_ch.value_in_range;
            if (pending_line_states.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("cycle %0d: line state with no request waiting", cycle_count);
            end
            else
            begin
                want = pending_line_states.pop_front();
                lines_checked++;
                bad = "";
                if (got.scl_out !== want.scl_out)               bad = {bad, " scl_out"};
                if (got.sda_out !== want.sda_out)               bad = {bad, " sda_out"};
                if (got.sda_drive !== want.sda_drive)           bad = {bad, " sda_drive"};
                if (got.ready_res !== want.ready_res)           bad = {bad, " ready_res"};
                if (got.done_res !== want.done_res)             bad = {bad, " done_res"};
                if (got.read_value !== want.read_value)         bad = {bad, " read_value"};
                if (got.parity_ok !== want.parity_ok)           bad = {bad, " parity_ok"};
                if (got.value_in_range !== want.value_in_range) bad = {bad, " value_in_range"};
                if (bad != "")
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                    begin
                        $display("cycle %0d: tick %0d differs in%s", cycle_count,
                                 lines_checked, bad);
                        $display("  expected scl %b sda %b drv %b rdy %b done %b val %0d par %b rng %b",
                                 want.scl_out, want.sda_out, want.sda_drive, want.ready_res,
                                 want.done_res, want.read_value, want.parity_ok,
                                 want.value_in_range);
                        $display("  actual   scl %b sda %b drv %b rdy %b done %b val %0d par %b rng %b",
                                 got.scl_out, got.sda_out, got.sda_drive, got.ready_res,
                                 got.done_res, got.read_value, got.parity_ok,
                                 got.value_in_range);
                    end
                end
            end
            stall_left = draw_gap(snk_idle_en);
            if (stall_left > 0)
                res_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            if (stall_left == 0)
                res_ch.ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("run stopped: no completion after %0d cycles", cycle_count);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n              = 1'b0;
        req_ch.valid       = 1'b0;
        req_ch.req_valid   = 1'b0;
        req_ch.req_type    = REQ_READ;
        req_ch.write_value = '0;
        req_ch.sda_in      = 1'b1;
        res_ch.ready       = 1'b1;
        cfg_ch.valid       = 1'b0;
        cfg_ch.data        = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_after_reset();
        test_directed_writes();
        test_directed_reads();
        test_hold_lengths();
        test_long_hold_change();
        test_random_traffic();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_line_states.size() != 0)
        begin
            mismatch_count++;
            $display("%0d line states never arrived", pending_line_states.size());
        end

        $display("Covered %0d ticks: %0d reads and %0d writes, holds of 0 to 12 ticks,",
                 ticks_sent, reads_started, writes_started);
        $display("a hold change in mid request, %0d line states checked, %0d mismatches.",
                 lines_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== parity_serial_sensor_master_top.f =====
hdl/pssm_pkg.sv
hdl/pssm_if.sv
hdl/pssm_front.sv
hdl/pssm_queue.sv
hdl/pssm_back.sv
hdl/parity_serial_sensor_master_top.sv
tb/tb_top.sv
